// ===== rtl/cdcep_pkg.sv =====
// types and constants shared by the cdc bulk endpoint finder
// no dependencies; imported by the walker and the top level
`default_nettype none

package cdcep_pkg;

  // walk phase of the descriptor parser
  typedef enum logic [1:0] {
    PH_SEARCH    = 2'd0,
    PH_ENDPOINTS = 2'd1,
    PH_DONE      = 2'd2
  } phase_t;

  // descriptor type codes
  localparam logic [7:0] DESC_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

  // endpoint address bit 7 marks an IN endpoint
  localparam int unsigned EP_DIR_BIT = 7;
  localparam logic [7:0]  NO_ADDRESS = 8'h00;

  // offsets of the wTotalLength bytes in the header
  localparam logic [15:0] OFF_TLEN_LO  = 16'd2;
  localparam logic [15:0] OFF_TLEN_HI  = 16'd3;
  localparam logic [15:0] OFF_HDR_END  = 16'd4;
  localparam logic [15:0] OFF_SAT      = 16'hFFFF;

  // byte positions inside an interface descriptor
  localparam logic [7:0] IF_POS_NUMBER = 8'd2;
  localparam logic [7:0] IF_POS_NUM_EP = 8'd4;
  localparam logic [7:0] IF_POS_CLASS  = 8'd5;

  // byte positions inside an endpoint descriptor
  localparam logic [7:0] EP_POS_ADDR = 8'd2;
  localparam logic [7:0] EP_POS_ATTR = 8'd3;

  // configuration register indexes and reset values
  localparam logic REG_TARGET_CLASS = 1'b0;
  localparam logic REG_XFER_TYPE    = 1'b1;
  localparam logic [7:0] TARGET_CLASS_RST = 8'd10;
  localparam logic [1:0] XFER_TYPE_RST    = 2'd2;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_endpoint;
    logic [7:0] in_endpoint;
    logic [7:0] interface_number;
    logic       interface_found;
    logic       both_found;
    logic       malformed;
  } out_beat_t;

  // parser state carried from byte to byte
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] total_len;
    logic [7:0]  pos;
    logic [7:0]  dlen;
    logic [7:0]  dtype;
    phase_t      phase;
    logic [7:0]  ep_left;
    logic [7:0]  pend_ep;
    logic [7:0]  out_ep;
    logic [7:0]  in_ep;
    logic [7:0]  if_num;
    logic        if_found;
    logic        bad;
  } walk_state_t;

  localparam walk_state_t WALK_RESET = '{
    offset:    16'd0,
    total_len: 16'hFFFF,
    pos:       8'd0,
    dlen:      8'd0,
    dtype:     8'd0,
    phase:     PH_SEARCH,
    ep_left:   8'd0,
    pend_ep:   8'd0,
    out_ep:    NO_ADDRESS,
    in_ep:     NO_ADDRESS,
    if_num:    8'd0,
    if_found:  1'b0,
    bad:       1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/cdcep_chan_if.sv =====
// valid/ready channel carrying one payload beat
// payload type is set by the instantiating level (see cdcep_pkg)
`default_nettype none

interface cdcep_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdcep_walk.sv =====
// next-state logic of the descriptor walker, one byte per evaluation
// depends on cdcep_pkg
`default_nettype none

module cdcep_walk
  import cdcep_pkg::*;
(
  input  walk_state_t cur,
  input  logic [7:0]  desc_byte,
  input  logic [7:0]  target_class,
  input  logic [1:0]  xfer_type,
  output walk_state_t nxt
);

  logic       in_range;
  logic       walking;
  logic       desc_end;
  logic [7:0] ep_dec;

  assign in_range = ((cur.offset < OFF_HDR_END) || (cur.offset < cur.total_len))
                    && (cur.offset != OFF_SAT);
  assign walking  = in_range && ((cur.phase == PH_SEARCH) || (cur.phase == PH_ENDPOINTS));
  assign ep_dec   = cur.ep_left - 8'd1;

  always_comb begin
    nxt      = cur;
    desc_end = 1'b0;

    if (walking) begin
      if ((cur.pos == 8'd0) && (desc_byte == 8'd0)) begin
        // zero bLength: flag and stop
        nxt.bad   = 1'b1;
        nxt.phase = PH_DONE;
      end else begin
        if (cur.pos == 8'd0) begin
          nxt.dlen  = desc_byte;
          nxt.dtype = 8'd0;
        end else if (cur.pos == 8'd1) begin
          nxt.dtype = desc_byte;
        end else if (cur.phase == PH_SEARCH) begin
          if ((cur.dtype == DESC_INTERFACE) && !cur.if_found) begin
            if (cur.pos == IF_POS_NUMBER) begin
              nxt.if_num = desc_byte;
            end else if (cur.pos == IF_POS_NUM_EP) begin
              nxt.ep_left = desc_byte;
            end else if ((cur.pos == IF_POS_CLASS) && (desc_byte == target_class)) begin
              nxt.if_found = 1'b1;
            end
          end
        end else if (cur.dtype == DESC_ENDPOINT) begin
          if (cur.pos == EP_POS_ADDR) begin
            nxt.pend_ep = desc_byte;
          end else if ((cur.pos == EP_POS_ATTR) && (desc_byte[1:0] == xfer_type)) begin
            if (cur.pend_ep[EP_DIR_BIT]) begin
              nxt.in_ep = cur.pend_ep;
            end else begin
              nxt.out_ep = cur.pend_ep;
            end
          end
        end

        desc_end = ({1'b0, cur.pos} + 9'd1) >= {1'b0, nxt.dlen};

        if (desc_end) begin
          nxt.pos = 8'd0;
          case (cur.phase)
            PH_SEARCH: begin
              if (nxt.if_found) begin
                nxt.phase = (nxt.ep_left != 8'd0) ? PH_ENDPOINTS : PH_DONE;
              end
            end
            PH_ENDPOINTS: begin
              nxt.ep_left = ep_dec;
              if (ep_dec == 8'd0) begin
                nxt.phase = PH_DONE;
              end
            end
            default: begin
              nxt.phase = cur.phase;
            end
          endcase
        end else begin
          nxt.pos = cur.pos + 8'd1;
        end
      end
    end

    // header length capture runs regardless of the walk
    if (cur.offset == OFF_TLEN_LO) begin
      nxt.total_len[7:0] = desc_byte;
    end else if (cur.offset == OFF_TLEN_HI) begin
      nxt.total_len[15:8] = desc_byte;
    end

    if (cur.offset != OFF_SAT) begin
      nxt.offset = cur.offset + 16'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usb_cdc_bulk_endpoint_finder.sv =====
// top level of the cdc bulk endpoint finder: channels, config registers, pipeline
// depends on cdcep_pkg, cdcep_chan_if and cdcep_walk
`default_nettype none

// Scans a USB configuration descriptor set delivered one byte per input beat and
// reports the first interface of the configured class together with its kept
// IN and OUT endpoint addresses (transfer type selectable, bulk after reset).
// wTotalLength is taken from header bytes 2 and 3; bytes beyond it are ignored,
// and a descriptor with bLength zero sets malformed and stops the walk. The beat
// flagged final_byte produces exactly one result beat and returns the parser to
// its reset state, so the next beat starts a new set; config registers are kept.
// Throughput is one byte per clock while the input side is not held; the only
// loop is the update of the parser state from the input stage register. The
// final byte is first loaded into the input stage register, and its result then
// into the result register that drives out_ch. The input stage keeps taking
// beats while a result waits on a stalled output; only a second final byte
// behind an untaken result holds the input side.
// Config: APB write at 0x0 sets target_interface_class, 0x4 sets
// accepted_transfer_type; write only while no set is in flight.

module usb_cdc_bulk_endpoint_finder
  import cdcep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  cdcep_chan_if.sink       in_ch,
  cdcep_chan_if.source     out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // config registers
  logic [7:0] target_class_r;
  logic [1:0] xfer_type_r;
  logic       cfg_wr;
  logic       cfg_idx;

  // input stage register
  logic       stg_valid_r;
  in_beat_t   stg_data_r;
  logic       stg_adv;
  logic       in_take;

  // parser state
  walk_state_t st_r;
  walk_state_t st_walk;

  // result register
  logic      out_valid_r;
  out_beat_t res_r;
  out_beat_t res_nxt;

  // ---------------------------------------------------------------------------
  // apb config port, zero wait states
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_class_r <= TARGET_CLASS_RST;
      xfer_type_r    <= XFER_TYPE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TARGET_CLASS: target_class_r <= cfg_pwdata[7:0];
        REG_XFER_TYPE:    xfer_type_r    <= cfg_pwdata[1:0];
        default: begin
          target_class_r <= target_class_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TARGET_CLASS: cfg_prdata = {24'd0, target_class_r};
      REG_XFER_TYPE:    cfg_prdata = {30'd0, xfer_type_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input stage: a beat moves on unless it is a final byte facing a full,
  // stalled result register
  // ---------------------------------------------------------------------------
  assign stg_adv     = stg_valid_r && (!stg_data_r.final_byte || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || stg_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_data_r <= in_ch.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // parser state update, one byte per beat
  // ---------------------------------------------------------------------------
  cdcep_walk u_walk (
    .cur          (st_r),
    .desc_byte    (stg_data_r.desc_byte),
    .target_class (target_class_r),
    .xfer_type    (xfer_type_r),
    .nxt          (st_walk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= WALK_RESET;
    end else if (stg_adv) begin
      // final byte closes the set and rearms for the next one
      st_r <= stg_data_r.final_byte ? WALK_RESET : st_walk;
    end
  end

  // ---------------------------------------------------------------------------
  // result register, built from the state after the final byte was walked
  // ---------------------------------------------------------------------------
  always_comb begin
    res_nxt.out_endpoint     = st_walk.out_ep;
    res_nxt.in_endpoint      = st_walk.in_ep;
    res_nxt.interface_number = st_walk.if_found ? st_walk.if_num : 8'd0;
    res_nxt.interface_found  = st_walk.if_found;
    res_nxt.both_found       = (st_walk.out_ep != NO_ADDRESS) && (st_walk.in_ep != NO_ADDRESS);
    res_nxt.malformed        = st_walk.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv && stg_data_r.final_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_data_r.final_byte) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = res_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // a final byte leaving the stage always lands a result
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && stg_data_r.final_byte) |=> out_valid_r)
    else $error("final byte did not produce a result");

  // a held stage beat is neither lost nor altered
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !stg_adv) |=> (stg_valid_r && $stable(stg_data_r)))
    else $error("stalled stage beat changed");

  // malformed always ends the walk
  a_bad_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bad |-> (st_r.phase == PH_DONE))
    else $error("malformed set still walking");

  // no interface number reported without a match
  a_ifnum_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.interface_found) |-> (res_r.interface_number == 8'd0))
    else $error("interface number without match");

  // the endpoint phase is only reached after a class match
  a_ep_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_ENDPOINTS) |-> st_r.if_found)
    else $error("endpoint phase without interface match");

endmodule

`default_nettype wire

// ===== verif/usb_cdc_bulk_endpoint_finder_tb.sv =====
// self-checking testbench for the cdc bulk endpoint finder: directed table, then random sets
// depends on cdcep_pkg, cdcep_chan_if and the usb_cdc_bulk_endpoint_finder rtl
`timescale 1ns / 1ps

module usb_cdc_bulk_endpoint_finder_tb;
  import cdcep_pkg::*;

  // cycles without any beat, config access or reset before the run is declared hung;
  // the longest legal quiet stretch is the receiver hold-off
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int BYTES_PER_SET = 180;
  localparam int N_PHASES      = 8;
  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_CS_IFACE  = 8'h24;
  localparam logic [7:0] DESC_CS_EP     = 8'h25;

  // results that can be read straight off a set in the directed table
  localparam out_beat_t NOTHING_FOUND = '0;
  localparam out_beat_t ZERO_LENGTH = '{out_endpoint: NO_ADDRESS, in_endpoint: NO_ADDRESS,
                                        interface_number: 8'd0, interface_found: 1'b0,
                                        both_found: 1'b0, malformed: 1'b1};
  localparam out_beat_t CDC_PAIR = '{out_endpoint: 8'h02, in_endpoint: 8'h81,
                                     interface_number: 8'h01, interface_found: 1'b1,
                                     both_found: 1'b1, malformed: 1'b0};

  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         pinned;
    out_beat_t  want;
  } plan_row_t;

  // directed sets, all under the reset settings (class 10, bulk):
  //   a zero bLength right at offset 0, a lone 0xff byte,
  //   a minimal cdc data interface with one bulk IN and one bulk OUT endpoint,
  //   a header whose wTotalLength is 4 so the trailing zero byte is ignored
  plan_row_t plan [25] = '{
    '{8'h00, 1'b1, 1'b1, ZERO_LENGTH},
    '{8'hFF, 1'b1, 1'b1, NOTHING_FOUND},
    '{8'h04, 1'b0, 1'b0, '0}, '{DESC_CONFIG, 1'b0, 1'b0, '0},
    '{8'd18, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h06, 1'b0, 1'b0, '0}, '{DESC_INTERFACE, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0}, '{TARGET_CLASS_RST, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0}, '{DESC_ENDPOINT, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0}, '{DESC_ENDPOINT, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0}, '{8'h02, 1'b1, 1'b1, CDC_PAIR},
    '{8'h04, 1'b0, 1'b0, '0}, '{DESC_CONFIG, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, NOTHING_FOUND}
  };

  // settings per phase: extremes of both registers, reset values revisited
  logic [7:0] class_plan [N_PHASES] = '{8'd10, 8'hFF, 8'h00, 8'd10, 8'h02, 8'h80, 8'd10, 8'h0A};
  logic [7:0] xfer_plan  [N_PHASES] = '{8'd2, 8'd3, 8'd0, 8'd2, 8'd1, 8'd0, 8'd2, 8'd2};

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cdcep_chan_if #(.T(in_beat_t))  in_ch ();
  cdcep_chan_if #(.T(out_beat_t)) out_ch ();

  usb_cdc_bulk_endpoint_finder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor copy of the parser and of the two registers
  walk_state_t trk;
  logic [7:0]  tgt_class;
  logic [1:0]  xfer_kind;

  out_beat_t   pending_results [$];
  logic [7:0]  set_q [$];
  int          fails;
  int          quiet_cycles;
  int          send_idle;
  int          stall_pct;
  int          hold_left;
  // a directed row may pin the result of its final beat instead of the predictor's
  bit          pin_use;
  out_beat_t   pin_res;

  always #5 clk = ~clk;

  task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // walk one byte through the predictor; emit is set on the beat that closes a set
  function automatic void scan_byte(in_beat_t beat, output bit emit, output out_beat_t res);
    logic [15:0] off;
    logic [7:0]  pos;
    logic [7:0]  b;
    bit          stop;
    off  = trk.offset;
    b    = beat.desc_byte;
    stop = 1'b0;
    emit = 1'b0;
    res  = '0;
    // header bytes are always walked, later ones only inside wTotalLength,
    // and nothing once the offset has saturated
    if ((off < OFF_HDR_END || off < trk.total_len) && off != OFF_SAT &&
        (trk.phase == PH_SEARCH || trk.phase == PH_ENDPOINTS)) begin
      pos = trk.pos;
      if (pos == 8'd0) begin
        if (b == 8'd0) begin
          // zero bLength: flag it and stop walking this set
          trk.bad   = 1'b1;
          trk.phase = PH_DONE;
          stop      = 1'b1;
        end else begin
          trk.dlen  = b;
          trk.dtype = 8'd0;
        end
      end else if (pos == 8'd1) begin
        trk.dtype = b;
      end else if (trk.phase == PH_SEARCH) begin
        if (trk.dtype == DESC_INTERFACE && !trk.if_found) begin
          if (pos == IF_POS_NUMBER) trk.if_num = b;
          else if (pos == IF_POS_NUM_EP) trk.ep_left = b;
          else if (pos == IF_POS_CLASS && b == tgt_class) trk.if_found = 1'b1;
        end
      end else if (trk.dtype == DESC_ENDPOINT) begin
        if (pos == EP_POS_ADDR) begin
          trk.pend_ep = b;
        end else if (pos == EP_POS_ATTR && b[1:0] == xfer_kind) begin
          if (trk.pend_ep[EP_DIR_BIT]) trk.in_ep = trk.pend_ep;
          else trk.out_ep = trk.pend_ep;
        end
      end
      if (!stop) begin
        if ({1'b0, pos} + 9'd1 >= {1'b0, trk.dlen}) begin
          // descriptor closed: move on through the endpoint count
          trk.pos = 8'd0;
          if (trk.phase == PH_SEARCH) begin
            if (trk.if_found) trk.phase = (trk.ep_left != 8'd0) ? PH_ENDPOINTS : PH_DONE;
          end else begin
            trk.ep_left = trk.ep_left - 8'd1;
            if (trk.ep_left == 8'd0) trk.phase = PH_DONE;
          end
        end else begin
          trk.pos = pos + 8'd1;
        end
      end
    end
    if (off == OFF_TLEN_LO) trk.total_len[7:0] = b;
    else if (off == OFF_TLEN_HI) trk.total_len[15:8] = b;
    if (off != OFF_SAT) trk.offset = off + 16'd1;
    if (beat.final_byte) begin
      emit                 = 1'b1;
      res.out_endpoint     = trk.out_ep;
      res.in_endpoint      = trk.in_ep;
      res.interface_number = trk.if_found ? trk.if_num : 8'd0;
      res.interface_found  = trk.if_found;
      res.both_found       = (trk.out_ep != NO_ADDRESS) && (trk.in_ep != NO_ADDRESS);
      res.malformed        = trk.bad;
      trk                  = WALK_RESET;
    end
  endfunction

  // append one descriptor of bLength len; bytes 1..6 come from f, the rest are random
  function automatic void put_desc(logic [7:0] len, logic [7:0] f [7]);
    set_q.push_back(len);
    for (int i = 1; i < int'(len); i++) set_q.push_back(i < 7 ? f[i] : rnd8());
  endfunction

  // one descriptor set: mostly well formed with random content, some broken, some noise
  function automatic void build_set();
    int          kind;
    int          n_ep;
    int          cut;
    int          sel;
    logic [7:0]  cls;
    logic [7:0]  attr;
    logic [15:0] tl;
    set_q.delete();
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 12)) set_q.push_back(rnd8());
      return;
    end
    put_desc(8'd9, '{8'h00, DESC_CONFIG, 8'h00, 8'h00, rnd8(), rnd8(), rnd8()});
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(19) == 0) begin
        // zero bLength somewhere in the chain
        set_q.push_back(8'h00);
        repeat ($urandom_range(0, 5)) set_q.push_back(rnd8());
      end
      if ($urandom_range(3) == 0)
        put_desc(8'($urandom_range(3, 6)),
                 '{8'h00, DESC_CS_IFACE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()});
      n_ep = $urandom_range(0, 3);
      cls  = ($urandom_range(9) < 7) ? tgt_class : rnd8();
      // short interface descriptors now and then
      put_desc(($urandom_range(9) == 0) ? 8'($urandom_range(1, 8)) : 8'd9,
               '{8'h00, DESC_INTERFACE, rnd8(), rnd8(), 8'(n_ep), cls, rnd8()});
      repeat (n_ep) begin
        attr = rnd8();
        if ($urandom_range(9) < 7) attr[1:0] = xfer_kind;
        if ($urandom_range(7) == 0)
          put_desc(8'($urandom_range(3, 7)),
                   '{8'h00, DESC_CS_EP, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()});
        else
          put_desc(($urandom_range(9) == 0) ? 8'($urandom_range(1, 6)) : 8'd7,
                   '{8'h00, DESC_ENDPOINT, rnd8(), attr, rnd8(), rnd8(), rnd8()});
      end
    end
    // wTotalLength: usually exact, sometimes cutting the chain, sometimes beyond it
    tl  = 16'(set_q.size());
    sel = $urandom_range(9);
    if (sel == 0) tl = 16'($urandom_range(0, set_q.size()));
    else if (sel == 1) tl = tl + 16'($urandom_range(1, 50));
    set_q[2] = tl[7:0];
    set_q[3] = tl[15:8];
    if (kind >= 70) begin
      cut = $urandom_range(1, set_q.size() - 1);
      if ($urandom_range(1) == 0) begin
        while (set_q.size() > cut) void'(set_q.pop_back());
      end else begin
        set_q[cut] = rnd8();
      end
    end
  endfunction

  // offer one beat after a random gap and hold it until taken
  task automatic push_byte(in_beat_t beat, bit pin, out_beat_t pin_val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pin_use = pin;
    pin_res = pin_val;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_set();
    int last;
    last = set_q.size() - 1;
    for (int i = 0; i <= last; i++)
      push_byte('{desc_byte: set_q[i], final_byte: (i == last)}, 1'b0, '0);
  endtask

  // apb write then read back; the predictor takes the new setting at the write edge
  task automatic write_setting(logic idx, logic [7:0] val);
    logic [31:0] keep;
    keep = (idx == REG_TARGET_CLASS) ? {24'd0, val} : {30'd0, val[1:0]};
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom), val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_TARGET_CLASS) tgt_class = val;
    else xfer_kind = val[1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== keep) log_mismatch("register readback", cfg_prdata, keep);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // result side: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check taken results against the oldest pending one, then predict from taken bytes
  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    out_beat_t res;
    bit        emit;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (pending_results.size() == 0) begin
          log_mismatch("result beat with nothing pending", 32'(got), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.out_endpoint !== want.out_endpoint)
            log_mismatch("out_endpoint", 32'(got.out_endpoint), 32'(want.out_endpoint));
          if (got.in_endpoint !== want.in_endpoint)
            log_mismatch("in_endpoint", 32'(got.in_endpoint), 32'(want.in_endpoint));
          if (got.interface_number !== want.interface_number)
            log_mismatch("interface_number", 32'(got.interface_number),
                         32'(want.interface_number));
          if (got.interface_found !== want.interface_found)
            log_mismatch("interface_found", 32'(got.interface_found),
                         32'(want.interface_found));
          if (got.both_found !== want.both_found)
            log_mismatch("both_found", 32'(got.both_found), 32'(want.both_found));
          if (got.malformed !== want.malformed)
            log_mismatch("malformed", 32'(got.malformed), 32'(want.malformed));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.payload, emit, res);
        if (emit) pending_results.push_back(pin_use ? pin_res : res);
      end
    end
  end

  // hang detector: any beat or config access restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("usb_cdc_bulk_endpoint_finder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    fails         = 0;
    quiet_cycles  = 0;
    send_idle     = 0;
    stall_pct     = 0;
    hold_left     = 0;
    pin_use       = 1'b0;
    pin_res       = '0;
    trk           = WALK_RESET;
    tgt_class     = TARGET_CLASS_RST;
    xfer_kind     = XFER_TYPE_RST;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < N_PHASES; p++) begin
      // phase 0 runs on the reset settings, the others rewrite both registers
      if (p != 0) begin
        write_setting(REG_TARGET_CLASS, class_plan[p]);
        write_setting(REG_XFER_TYPE, xfer_plan[p]);
        @(posedge clk);
      end
      // idle mix: none, sender gaps, receiver stalls, light gaps on both
      case (p % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 56; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 56; end
        default: begin send_idle = 10; stall_pct = 10; end
      endcase
      // back-pressure: the result side holds off while bytes keep coming,
      // so a second final byte behind the parked result stalls the input
      if (p == 4) hold_left = HOLD_CYCLES;

      if (p == 0) begin
        foreach (plan[i])
          push_byte('{desc_byte: plan[i].b, final_byte: plan[i].fin}, plan[i].pinned, plan[i].want);
      end

      sent = 0;
      while (sent < BYTES_PER_SET) begin
        build_set();
        send_set();
        sent += set_q.size();
      end
      @(negedge clk);
      in_ch.valid <= 1'b0;
      // drain before touching the registers again
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("usb_cdc_bulk_endpoint_finder regression: pass");
    end else begin
      $display("usb_cdc_bulk_endpoint_finder regression: fail");
    end
    $finish;
  end

endmodule
